[src/tke_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tke_pkg: shared types and constants of the touch keypad entry unit
// Item formats, key event codes, configuration indexes and screen/grid
// geometry used by the front, the command queue and the back.
// ----------------------------------------------------------------------------
package tke_pkg;

	// Defaults for the top level parameters
	localparam int MAX_DIGITS_DEF    = 10;
	localparam int DEBOUNCE_TIME_DEF = 60;

	// Digits shown on the result port and its width
	localparam int SHOWN_DIGITS = 10;
	localparam int ENTRY_BITS   = 4 * SHOWN_DIGITS;

	// Screen size after mirroring
	localparam int SCR_W = 240;
	localparam int SCR_H = 320;

	// Key grid geometry
	localparam int GRID_X0  = 8;
	localparam int GRID_Y0  = 112;
	localparam int CELL_W   = 68;
	localparam int CELL_H   = 47;
	localparam int CELL_GAP = 3;
	localparam int GRID_ROWS = 4;
	localparam int GRID_COLS = 3;

	// Depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Key event codes (also the command kinds passed front to back)
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_DIGIT = 2'd1;
	localparam logic [1:0] EV_DEL   = 2'd2;
	localparam logic [1:0] EV_OK    = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_DIGIT_FORWARD  = 2'd0;
	localparam logic [1:0] CFG_DELETE_FORWARD = 2'd1;
	localparam logic [1:0] CFG_OK_FORWARD     = 2'd2;

	typedef struct packed {
		logic        touched;
		logic [31:0] now_ms;
		logic [11:0] raw_x;
		logic [11:0] raw_y;
	} in_item_t;

	typedef struct packed {
		logic [1:0]            key_event;
		logic [3:0]            key_digit;
		logic                  forwarded;
		logic                  entry_changed;
		logic [ENTRY_BITS-1:0] entry_digits;
		logic [3:0]            entry_length;
	} out_item_t;

	// Classified press handed from front to back
	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] digit;
	} cmd_t;

	typedef struct packed {
		logic digit_forward;
		logic delete_forward;
		logic ok_forward;
	} cfg_t;

endpackage

[src/tke_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tke_front: press acceptance and key classification
// Debounces touch polls, mirrors and clamps the point and hit-tests it
// against the 3 x 4 key grid, pushing one command per item into the queue.
// ----------------------------------------------------------------------------
module tke_front #(
	parameter int DEBOUNCE_TIME = tke_pkg::DEBOUNCE_TIME_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  tke_pkg::in_item_t in_item,
	input  logic              q_full,
	output logic              push,
	output tke_pkg::cmd_t     cmd
);

	localparam logic [3:0] KEY_DEL = 4'd10;
	localparam logic [3:0] KEY_OK  = 4'd11;

	// Key labels by row: 1 2 3 / 4 5 6 / 7 8 9 / DEL 0 OK
	localparam logic [3:0] KEY_MAP [tke_pkg::GRID_ROWS][tke_pkg::GRID_COLS] = '{
		'{4'd1, 4'd2, 4'd3},
		'{4'd4, 4'd5, 4'd6},
		'{4'd7, 4'd8, 4'd9},
		'{KEY_DEL, 4'd0, KEY_OK}
	};

	logic        released_q;
	logic [31:0] last_time_q;
	logic [31:0] elapsed;
	logic        press;
	logic [7:0]  tx;
	logic [8:0]  ty;
	logic [tke_pkg::GRID_COLS-1:0] col_hit;
	logic [tke_pkg::GRID_ROWS-1:0] row_hit;
	logic        hit;
	logic [3:0]  key;
	logic        accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept;

	// Debounce: release seen and enough time gone since the last press
	assign elapsed = in_item.now_ms - last_time_q;
	assign press   = in_item.touched && released_q && (elapsed >= 32'(DEBOUNCE_TIME));

	// Mirror and clamp the raw point onto the screen
	always_comb begin
		if (in_item.raw_x == 12'd0) begin
			tx = 8'(tke_pkg::SCR_W - 1);
		end else if (in_item.raw_x >= 12'(tke_pkg::SCR_W)) begin
			tx = 8'd0;
		end else begin
			tx = 8'(12'(tke_pkg::SCR_W) - in_item.raw_x);
		end
		if (in_item.raw_y == 12'd0) begin
			ty = 9'(tke_pkg::SCR_H - 1);
		end else if (in_item.raw_y >= 12'(tke_pkg::SCR_H)) begin
			ty = 9'd0;
		end else begin
			ty = 9'(12'(tke_pkg::SCR_H) - in_item.raw_y);
		end
	end

	// Compare against every column and row band in parallel
	always_comb begin
		for (int c = 0; c < tke_pkg::GRID_COLS; c++) begin
			col_hit[c] = ({1'b0, tx} >=
					9'(tke_pkg::GRID_X0 + c * (tke_pkg::CELL_W + tke_pkg::CELL_GAP))) &&
				({1'b0, tx} < 9'(tke_pkg::GRID_X0 +
					c * (tke_pkg::CELL_W + tke_pkg::CELL_GAP) + tke_pkg::CELL_W));
		end
		for (int r = 0; r < tke_pkg::GRID_ROWS; r++) begin
			row_hit[r] = (ty >=
					9'(tke_pkg::GRID_Y0 + r * (tke_pkg::CELL_H + tke_pkg::CELL_GAP))) &&
				(ty < 9'(tke_pkg::GRID_Y0 +
					r * (tke_pkg::CELL_H + tke_pkg::CELL_GAP) + tke_pkg::CELL_H));
		end
	end

	// Pick the key under the point; bands are disjoint so at most one hits
	always_comb begin
		hit = 1'b0;
		key = 4'd0;
		for (int r = 0; r < tke_pkg::GRID_ROWS; r++) begin
			for (int c = 0; c < tke_pkg::GRID_COLS; c++) begin
				if (row_hit[r] && col_hit[c]) begin
					hit = 1'b1;
					key = KEY_MAP[r][c];
				end
			end
		end
	end

	// Classify the item into a command for the back
	always_comb begin
		cmd.kind  = tke_pkg::EV_NONE;
		cmd.digit = 4'd0;
		if (press && hit) begin
			if (key == KEY_DEL) begin
				cmd.kind = tke_pkg::EV_DEL;
			end else if (key == KEY_OK) begin
				cmd.kind = tke_pkg::EV_OK;
			end else begin
				cmd.kind  = tke_pkg::EV_DIGIT;
				cmd.digit = key;
			end
		end
	end

	// Track release and the time of the last accepted press
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			released_q  <= 1'b1;
			last_time_q <= 32'd0;
		end else if (accept) begin
			if (!in_item.touched) begin
				released_q <= 1'b1;
			end else if (press) begin
				released_q  <= 1'b0;
				last_time_q <= in_item.now_ms;
			end
		end
	end

endmodule

[src/tke_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tke_queue: command queue between front and back
// Small FIFO that lets the front keep accepting while the back is stalled.
// ----------------------------------------------------------------------------
module tke_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tke_pkg::cmd_t push_cmd,
	output logic          full,
	output logic          pop_valid,
	input  logic          pop,
	output tke_pkg::cmd_t pop_cmd
);

	localparam int PW = (tke_pkg::QUEUE_DEPTH > 1) ? $clog2(tke_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(tke_pkg::QUEUE_DEPTH + 1);

	tke_pkg::cmd_t slot_q [tke_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == CW'(tke_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd   = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	// Store pushed items
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(tke_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(tke_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/tke_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tke_back: entry editing and result register
// Applies each command to the stored digit entry and registers the result
// item, holding it while the output side stalls.
// ----------------------------------------------------------------------------
module tke_back #(
	parameter int MAX_DIGITS = tke_pkg::MAX_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tke_pkg::cfg_t      cfg,
	input  logic               cmd_valid,
	output logic               cmd_pop,
	input  tke_pkg::cmd_t      cmd,
	output logic               out_valid,
	input  logic               out_stall,
	output tke_pkg::out_item_t out_item
);

	localparam int CW    = $clog2(MAX_DIGITS + 1);
	localparam int IW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int SHOWN = (MAX_DIGITS < tke_pkg::SHOWN_DIGITS) ?
		MAX_DIGITS : tke_pkg::SHOWN_DIGITS;

	logic [3:0]         store_q [MAX_DIGITS];
	logic [3:0]         store_n [MAX_DIGITS];
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_n;
	logic [CW-1:0]      count_dec;
	logic               out_valid_q;
	tke_pkg::out_item_t out_item_q;
	tke_pkg::out_item_t res;
	logic               take;

	assign take      = cmd_valid && (!out_valid_q || !out_stall);
	assign cmd_pop   = take;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign count_dec = count_q - 1'b1;

	// Apply the command to the entry
	always_comb begin
		store_n = store_q;
		count_n = count_q;
		res     = '0;
		case (cmd.kind)
			tke_pkg::EV_DIGIT: begin
				res.key_event = tke_pkg::EV_DIGIT;
				res.key_digit = cmd.digit;
				if (cfg.digit_forward) begin
					res.forwarded = 1'b1;
				end else if (count_q < CW'(MAX_DIGITS)) begin
					res.entry_changed = 1'b1;
					if (count_q == CW'(1) && store_q[0] == 4'd0) begin
						// replace a lone zero
						store_n[0] = cmd.digit;
						count_n    = CW'(1);
					end else begin
						store_n[count_q[IW-1:0]] = cmd.digit;
						count_n                  = count_q + 1'b1;
					end
				end
			end
			tke_pkg::EV_DEL: begin
				res.key_event = tke_pkg::EV_DEL;
				if (cfg.delete_forward) begin
					res.forwarded = 1'b1;
				end else if (count_q != '0) begin
					res.entry_changed          = 1'b1;
					store_n[count_dec[IW-1:0]] = 4'd0;
					count_n                    = count_dec;
				end
			end
			tke_pkg::EV_OK: begin
				if (cfg.ok_forward) begin
					res.key_event = tke_pkg::EV_OK;
					res.forwarded = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Pack the shown digits, first digit in the high nibble
		for (int i = 0; i < SHOWN; i++) begin
			if (CW'(i) < count_n) begin
				res.entry_digits[4 * (tke_pkg::SHOWN_DIGITS - 1 - i) +: 4] = store_n[i];
			end
		end
		res.entry_length = 4'(count_n);
	end

	// Update the entry on each command taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < MAX_DIGITS; i++) begin
				store_q[i] <= 4'd0;
			end
		end else if (take) begin
			count_q <= count_n;
			store_q <= store_n;
		end
	end

	// Hold the result until the output side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_item_q <= res;
		end
	end

endmodule

[src/touch_keypad_entry_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_keypad_entry_unit: debounced 3 x 4 touch keypad with digit entry
// Top level: configuration registers, front, command queue and back.
// ----------------------------------------------------------------------------
// Each input item is one touch poll and yields exactly one result item. The
// unit takes one item per clock cycle while in_stall is low. An accepted item
// is written into the front-to-back queue and taken from there into the
// result register, from which its result is offered. Input stalls only while
// the queue is full; after an output stall that fills the queue, input stays
// stalled while the back takes from the full queue, since the stall looks at
// the fill count only. A press counts only after a release and DEBOUNCE_TIME
// ms after the last counted press; the point is mirrored onto a 240 x 320
// screen and matched to the key grid. Digit keys append to a stored entry of
// up to MAX_DIGITS digits (a lone 0 is replaced), DEL removes the last digit
// and OK only reports; the configuration bits turn digit and DEL presses into
// reported events and enable OK reports. A two-entry queue keeps input
// accepting while the result side stalls; write configuration only when idle.
module touch_keypad_entry_unit #(
	parameter int MAX_DIGITS    = tke_pkg::MAX_DIGITS_DEF,
	parameter int DEBOUNCE_TIME = tke_pkg::DEBOUNCE_TIME_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [1:0]         cfg_index,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  tke_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output tke_pkg::out_item_t out_item
);

	tke_pkg::cfg_t cfg_q;
	tke_pkg::cmd_t push_cmd;
	tke_pkg::cmd_t pop_cmd;
	logic          push;
	logic          q_full;
	logic          q_valid;
	logic          q_pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				tke_pkg::CFG_DIGIT_FORWARD:  cfg_q.digit_forward  <= cfg_wdata;
				tke_pkg::CFG_DELETE_FORWARD: cfg_q.delete_forward <= cfg_wdata;
				tke_pkg::CFG_OK_FORWARD:     cfg_q.ok_forward     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	tke_front #(
		.DEBOUNCE_TIME(DEBOUNCE_TIME)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item (in_item),
		.q_full  (q_full),
		.push    (push),
		.cmd     (push_cmd)
	);

	tke_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop_valid(q_valid),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd)
	);

	tke_back #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(q_valid),
		.cmd_pop  (q_pop),
		.cmd      (pop_cmd),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

endmodule

[tb/tb_touch_keypad_entry_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_keypad_entry_unit: self-checking bench for the touch keypad unit
// Feeds touch polls through the valid/stall input channel and checks every
// result item against a cycle-free prediction of debounce, mirroring, key
// hit-test and entry editing. A short directed run covers the corner cases,
// then phases of random press sequences run under several register settings
// with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_touch_keypad_entry_unit;

	// Key codes produced by the grid hit-test
	localparam int KEY_NONE = -1;
	localparam int KEY_DEL  = 10;
	localparam int KEY_OK   = 11;

	// Unused register index, writes to it must be ignored
	localparam logic [1:0] CFG_SPARE = 2'd3;

	localparam int TAP_SPACING_MS    = 100;
	localparam int PRESSES_PER_PHASE = 70;
	localparam int PHASES            = 8;

	logic                clk;
	logic                arst_n;
	logic                cfg_wen;
	logic [1:0]          cfg_index;
	logic                cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	tke_pkg::in_item_t   in_item;
	logic                out_valid;
	logic                out_stall;
	tke_pkg::out_item_t  out_item;

	logic [31:0] clock_ms;
	bit          no_idle;

	touch_keypad_entry_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// Label of the key at grid row r, column c
	function automatic int key_at(int r, int c);
		if (r < tke_pkg::GRID_ROWS - 1) begin
			return tke_pkg::GRID_COLS * r + c + 1;
		end
		if (c == 0) begin
			return KEY_DEL;
		end
		if (c == 1) begin
			return 0;
		end
		return KEY_OK;
	endfunction

	// Tracks the entry state and holds the results still owed by the unit
	class keypad_result_board;
		tke_pkg::cfg_t      regs;
		bit                 released;
		logic [31:0]        last_press_ms;
		logic [3:0]         digits_held[16];
		int                 held_count;
		tke_pkg::out_item_t expected_results[$];
		int                 mismatches;
		int                 results_seen;

		function new();
			regs          = '0;
			released      = 1'b1;
			last_press_ms = '0;
			foreach (digits_held[i]) digits_held[i] = '0;
			held_count    = 0;
			mismatches    = 0;
			results_seen  = 0;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void write_reg(logic [1:0] idx, logic val);
			case (idx)
				tke_pkg::CFG_DIGIT_FORWARD:  regs.digit_forward  = val;
				tke_pkg::CFG_DELETE_FORWARD: regs.delete_forward = val;
				tke_pkg::CFG_OK_FORWARD:     regs.ok_forward     = val;
				default: ;
			endcase
		endfunction

		// Work out the result of one poll and advance the entry state
		function tke_pkg::out_item_t predict_poll(tke_pkg::in_item_t it);
			tke_pkg::out_item_t res;
			int                 tx, ty, key, x0, y0;
			logic [31:0]        elapsed;
			res     = '0;
			key     = KEY_NONE;
			elapsed = it.now_ms - last_press_ms;
			if (!it.touched) begin
				released = 1'b1;
			end else if (released && elapsed >= 32'(tke_pkg::DEBOUNCE_TIME_DEF)) begin
				// mirror and clamp onto the screen
				tx = tke_pkg::SCR_W - int'(it.raw_x);
				ty = tke_pkg::SCR_H - int'(it.raw_y);
				tx = (tx < 0) ? 0 : ((tx > tke_pkg::SCR_W - 1) ? tke_pkg::SCR_W - 1 : tx);
				ty = (ty < 0) ? 0 : ((ty > tke_pkg::SCR_H - 1) ? tke_pkg::SCR_H - 1 : ty);
				for (int r = 0; r < tke_pkg::GRID_ROWS; r++) begin
					for (int c = 0; c < tke_pkg::GRID_COLS; c++) begin
						x0 = tke_pkg::GRID_X0 + c * (tke_pkg::CELL_W + tke_pkg::CELL_GAP);
						y0 = tke_pkg::GRID_Y0 + r * (tke_pkg::CELL_H + tke_pkg::CELL_GAP);
						if (tx >= x0 && tx < x0 + tke_pkg::CELL_W &&
						    ty >= y0 && ty < y0 + tke_pkg::CELL_H &&
						    key == KEY_NONE) begin
							key = key_at(r, c);
						end
					end
				end
				released      = 1'b0;
				last_press_ms = it.now_ms;
				if (key >= 0 && key < KEY_DEL) begin
					res.key_event = tke_pkg::EV_DIGIT;
					res.key_digit = 4'(key);
					if (regs.digit_forward) begin
						res.forwarded = 1'b1;
					end else if (held_count < tke_pkg::MAX_DIGITS_DEF) begin
						// a lone zero gets replaced
						if (held_count == 1 && digits_held[0] == 4'd0) begin
							held_count = 0;
						end
						digits_held[held_count] = 4'(key);
						held_count++;
						res.entry_changed = 1'b1;
					end
				end else if (key == KEY_DEL) begin
					res.key_event = tke_pkg::EV_DEL;
					if (regs.delete_forward) begin
						res.forwarded = 1'b1;
					end else if (held_count > 0) begin
						held_count--;
						digits_held[held_count] = '0;
						res.entry_changed = 1'b1;
					end
				end else if (key == KEY_OK && regs.ok_forward) begin
					res.key_event = tke_pkg::EV_OK;
					res.forwarded = 1'b1;
				end
			end
			for (int i = 0; i < tke_pkg::SHOWN_DIGITS && i < held_count; i++) begin
				res.entry_digits[4 * (tke_pkg::SHOWN_DIGITS - 1 - i) +: 4] = digits_held[i];
			end
			res.entry_length = 4'(held_count);
			return res;
		endfunction

		function void note_poll(tke_pkg::in_item_t it);
			expected_results.push_back(predict_poll(it));
		endfunction

		task report_mismatch(string msg);
			$display("%0t result %0d: %s", $time, results_seen, msg);
			mismatches++;
		endtask

		task compare_field(string name, logic [tke_pkg::ENTRY_BITS-1:0] got,
			logic [tke_pkg::ENTRY_BITS-1:0] want);
			if (got !== want) begin
				report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
			end
		endtask

		task check_result(tke_pkg::out_item_t got);
			tke_pkg::out_item_t want;
			if (expected_results.size() == 0) begin
				report_mismatch("result with no poll outstanding");
				return;
			end
			want = expected_results.pop_front();
			compare_field("key_event", got.key_event, want.key_event);
			compare_field("key_digit", got.key_digit, want.key_digit);
			compare_field("forwarded", got.forwarded, want.forwarded);
			compare_field("entry_changed", got.entry_changed, want.entry_changed);
			compare_field("entry_digits", got.entry_digits, want.entry_digits);
			compare_field("entry_length", got.entry_length, want.entry_length);
			results_seen++;
		endtask
	endclass

	keypad_result_board board = new();

	// Clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Give up after a generous fixed time
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Random point inside the cell of the given key, as raw coordinates
	function automatic logic [23:0] key_point(int key);
		int          tx, ty;
		logic [23:0] pt;
		pt = '0;
		for (int r = 0; r < tke_pkg::GRID_ROWS; r++) begin
			for (int c = 0; c < tke_pkg::GRID_COLS; c++) begin
				if (key_at(r, c) == key) begin
					tx = tke_pkg::GRID_X0 + c * (tke_pkg::CELL_W + tke_pkg::CELL_GAP) +
						$urandom_range(0, tke_pkg::CELL_W - 1);
					ty = tke_pkg::GRID_Y0 + r * (tke_pkg::CELL_H + tke_pkg::CELL_GAP) +
						$urandom_range(0, tke_pkg::CELL_H - 1);
					pt = {12'(tke_pkg::SCR_W - tx), 12'(tke_pkg::SCR_H - ty)};
				end
			end
		end
		return pt;
	endfunction

	// Offer one item after a random gap and hold it until taken
	task automatic send(input tke_pkg::in_item_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		board.note_poll(it);
	endtask

	// Release, then press at the given point gap_ms later
	task automatic tap(input logic [23:0] pt, input int gap_ms);
		tke_pkg::in_item_t it;
		it         = '0;
		it.now_ms  = clock_ms;
		it.raw_x   = 12'($urandom_range(0, 4095));
		it.raw_y   = 12'($urandom_range(0, 4095));
		send(it);
		clock_ms  += 32'(gap_ms);
		it.touched = 1'b1;
		it.now_ms  = clock_ms;
		{it.raw_x, it.raw_y} = pt;
		send(it);
	endtask

	// Drop valid and wait for every owed result, then let the pipe settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (board.pending() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		board.write_reg(idx, val);
	endtask

	task automatic apply_config(input tke_pkg::cfg_t c);
		write_reg(tke_pkg::CFG_DIGIT_FORWARD, c.digit_forward);
		write_reg(tke_pkg::CFG_DELETE_FORWARD, c.delete_forward);
		write_reg(tke_pkg::CFG_OK_FORWARD, c.ok_forward);
		write_reg(CFG_SPARE, 1'($urandom_range(0, 1)));
		cfg_wen <= 1'b0;
	endtask

	// Result side: stall at random, check every item taken
	initial begin
		int n;
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 11);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			board.check_result(out_item);
		end
	end

	// Stimulus
	initial begin
		tke_pkg::in_item_t it;
		logic [23:0]       pt;
		int                roll, w;
		tke_pkg::cfg_t     c;

		arst_n    <= 1'b0;
		cfg_wen   <= 1'b0;
		cfg_index <= tke_pkg::CFG_DIGIT_FORWARD;
		cfg_wdata <= 1'b0;
		in_valid  <= 1'b0;
		in_item   <= '0;
		clock_ms   = '0;
		no_idle    = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		apply_config('0);

		// release with every field at its top, then a press inside debounce after reset
		it = '1;
		it.touched = 1'b0;
		send(it);
		it.touched = 1'b1;
		it.now_ms  = 32'd10;
		{it.raw_x, it.raw_y} = key_point(1);
		send(it);

		// lone zero set and replaced by zero, delete down to empty and beyond, hidden OK
		clock_ms = 32'd100;
		tap(key_point(0), TAP_SPACING_MS);
		tap(key_point(0), TAP_SPACING_MS);
		tap(key_point(KEY_DEL), TAP_SPACING_MS);
		tap(key_point(KEY_DEL), TAP_SPACING_MS);
		tap(key_point(KEY_OK), TAP_SPACING_MS);

		// clamped extremes land off the grid
		tap('0, TAP_SPACING_MS);
		tap('1, TAP_SPACING_MS);

		// held touch with no release in between
		clock_ms  += 32'd200;
		it.now_ms  = clock_ms;
		{it.raw_x, it.raw_y} = key_point(5);
		send(it);

		// time wraps between release and press
		clock_ms = 32'hFFFF_FFC0;
		tap(key_point(7), TAP_SPACING_MS);

		// one short of the debounce time, then exactly on it
		tap(key_point(9), tke_pkg::DEBOUNCE_TIME_DEF - 1);
		tap(key_point(9), 1);

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			if (phase == 0 || phase == 2) begin
				c = '0;
			end else if (phase == 1) begin
				c = '1;
			end else begin
				c = tke_pkg::cfg_t'($urandom_range(0, 7));
			end
			apply_config(c);
			no_idle = (phase % 3 == 2);

			for (int p = 0; p < PRESSES_PER_PHASE; p++) begin
				// hold off until every owed result is in
				if (phase == 3 && p == PRESSES_PER_PHASE / 2) begin
					wait_idle();
				end

				// occasional noise poll
				if ($urandom_range(0, 99) < 8) begin
					it.touched = 1'($urandom_range(0, 1));
					it.now_ms  = $urandom;
					it.raw_x   = 12'($urandom_range(0, 4095));
					it.raw_y   = 12'($urandom_range(0, 4095));
					send(it);
				end

				// release
				repeat ($urandom_range(1, 2)) begin
					it.touched = 1'b0;
					it.now_ms  = clock_ms;
					it.raw_x   = 12'($urandom_range(0, 4095));
					it.raw_y   = 12'($urandom_range(0, 4095));
					send(it);
					clock_ms += 32'($urandom_range(0, 30));
				end

				// advance time: mostly past debounce, sometimes bounce or jump
				roll = $urandom_range(0, 99);
				if (roll < 12) begin
					clock_ms += 32'($urandom_range(0, tke_pkg::DEBOUNCE_TIME_DEF - 1));
				end else if (roll < 17) begin
					clock_ms = $urandom;
				end else begin
					clock_ms += 32'($urandom_range(tke_pkg::DEBOUNCE_TIME_DEF, 400));
				end

				// press
				roll = $urandom_range(0, 99);
				if (roll < 65) begin
					pt = key_point($urandom_range(0, 9));
				end else if (roll < 77) begin
					pt = key_point(KEY_DEL);
				end else if (roll < 85) begin
					pt = key_point(KEY_OK);
				end else begin
					pt = {12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095))};
				end
				it.touched = 1'b1;
				it.now_ms  = clock_ms;
				{it.raw_x, it.raw_y} = pt;
				send(it);

				// hold the touch a little
				repeat ($urandom_range(0, 2)) begin
					clock_ms  += 32'($urandom_range(1, 40));
					it.now_ms  = clock_ms;
					send(it);
				end
			end
		end

		// drain with a limit, then settle
		in_valid <= 1'b0;
		for (w = 0; w < 2000 && board.pending() > 0; w++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.pending() > 0) begin
			board.report_mismatch($sformatf("%0d results never arrived", board.pending()));
		end
		if (board.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
